FILE: rtl/sss_pkg.sv
package sss_pkg;

	localparam int TARGET_DEPTH = 4;
	localparam int CNT_W        = $clog2(TARGET_DEPTH + 1);

	typedef logic signed [7:0] angle_t;
	typedef logic [CNT_W-1:0]  count_t;

	typedef struct packed {
		logic       opcode;
		logic       working_mode;
		logic [3:0] sensor_code;
		logic [9:0] pot_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0] duty_value;
		logic [2:0] zone_lights;
		angle_t     angle_now;
		logic       busy_res;
		logic [2:0] speed_now;
	} res_t;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_COMMAND = 1'b1;

	localparam logic [3:0] SENSOR_LEFT         = 4'h9;
	localparam logic [3:0] SENSOR_CENTER       = 4'hA;
	localparam logic [3:0] SENSOR_LEFT_CENTER  = 4'hB;
	localparam logic [3:0] SENSOR_RIGHT        = 4'hC;
	localparam logic [3:0] SENSOR_SWEEP_A      = 4'hD;
	localparam logic [3:0] SENSOR_CENTER_RIGHT = 4'hE;
	localparam logic [3:0] SENSOR_SWEEP_B      = 4'hF;

	localparam angle_t ANGLE_MIN = -8'sd90;
	localparam angle_t ANGLE_MID = 8'sd0;
	localparam angle_t ANGLE_MAX = 8'sd90;
	localparam angle_t ZONE_EDGE = 8'sd45;

	localparam logic [2:0] SPEED_RESET = 3'd5;
	localparam logic [2:0] SPAN_BASE   = 3'd6;

	localparam logic [7:0]  DUTY_CENTER = 8'd187;
	// 31/45 scaled by 2^20, exact for magnitudes up to 90
	localparam logic [19:0] DUTY_RECIP  = 20'd722362;
	localparam int          DUTY_SHIFT  = 20;

	// 18/5 scaled by 2^10, exact for indexes up to 50
	localparam logic [11:0] IDX_RECIP = 12'd3690;
	localparam int          IDX_SHIFT = 10;

	localparam logic [10:0] POT_FULL = 11'd1023;

	// x / 1023 for x below 1023 * 64
	function automatic logic [5:0] div_1023(input logic [15:0] x);
		logic [5:0]  q0;
		logic [10:0] r;
		q0 = x[15:10];
		r  = {1'b0, x[9:0]} + {5'd0, q0};
		return q0 + 6'((r >= POT_FULL) ? 1 : 0);
	endfunction

	function automatic angle_t idle_target(input logic [5:0] idx);
		logic [17:0] p;
		logic [8:0]  t;
		p = 18'(idx) * 18'(IDX_RECIP);
		t = {1'b0, p[IDX_SHIFT +: 8]};
		return angle_t'($signed(t) - 9'sd90);
	endfunction

	function automatic logic [7:0] duty_of(input angle_t a);
		logic [6:0]  mag;
		logic [26:0] prod;
		logic [7:0]  q;
		mag  = a[7] ? 7'(-a) : a[6:0];
		prod = 27'(mag) * 27'(DUTY_RECIP);
		q    = {1'b0, prod[DUTY_SHIFT +: 7]};
		return a[7] ? DUTY_CENTER - q : DUTY_CENTER + q;
	endfunction

	function automatic logic [2:0] zone_of(input angle_t a);
		logic [2:0] z;
		z[0] = (a <= ANGLE_MID);
		z[1] = (a > -ZONE_EDGE) && (a <= ZONE_EDGE);
		z[2] = (a > ANGLE_MID);
		return z;
	endfunction

endpackage

FILE: rtl/servo_sweep_sequencer.sv
// channel | dir | handshake             | payload
// cmd     | in  | cmd_valid / cmd_ready | sss_pkg::cmd_t (tick or command sample)
// res     | out | res_valid / res_ready | sss_pkg::res_t (one per cmd transaction)
//
// One transaction per cycle unless res stalls; cmd goes via input and result regs.
// Potentiometer scaling is done ahead of the input register, the step, target
// drop and duty math between the input register and the result register.
// arst_n clears control state; the target list holds no reset value.
// A stalled res holds the input register and drops cmd_ready once it is full.
module servo_sweep_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  sss_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output sss_pkg::res_t res
);

	logic       valid_s1;
	logic       op_s1;
	logic       wm_s1;
	logic [3:0] code_s1;
	logic [2:0] speed_s1;
	logic [5:0] idx_s1;

	logic [5:0] speed_cmd;
	logic [5:0] idx_cmd;
	logic       adv;

	sss_pkg::angle_t angle_q;
	sss_pkg::angle_t tgt_q [sss_pkg::TARGET_DEPTH];
	sss_pkg::count_t count_q;
	logic [2:0]      speed_q;
	logic [2:0]      ticks_q;
	logic [7:0]      duty_q;
	logic [2:0]      light_q;

	sss_pkg::angle_t angle_n;
	sss_pkg::angle_t tgt_n   [sss_pkg::TARGET_DEPTH];
	sss_pkg::angle_t list_pre[sss_pkg::TARGET_DEPTH];
	sss_pkg::count_t cnt_pre;
	sss_pkg::count_t drop_k;
	sss_pkg::count_t count_n;
	logic [2:0]      speed_n;
	logic [2:0]      ticks_n;
	logic [2:0]      tick_inc;
	logic [7:0]      duty_n;
	logic [2:0]      light_n;
	logic            run;
	sss_pkg::res_t   res_n;

	assign speed_cmd = sss_pkg::div_1023(16'(cmd.pot_value) * 16'd5);
	assign idx_cmd   = sss_pkg::div_1023(16'(cmd.pot_value) * 16'd50);

	assign adv       = valid_s1 && (!res_valid || res_ready);
	assign cmd_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			op_s1    <= cmd.opcode;
			wm_s1    <= cmd.working_mode;
			code_s1  <= cmd.sensor_code;
			speed_s1 <= speed_cmd[2:0];
			idx_s1   <= idx_cmd;
		end
	end

	always_comb begin
		angle_n  = angle_q;
		speed_n  = speed_q;
		ticks_n  = ticks_q;
		duty_n   = duty_q;
		light_n  = light_q;
		list_pre = tgt_q;
		cnt_pre  = count_q;
		tick_inc = ticks_q + 3'd1;

		if (op_s1 == sss_pkg::OP_COMMAND) begin
			if (count_q == '0) begin
				if (wm_s1) begin
					speed_n = speed_s1;
					unique case (code_s1)
						sss_pkg::SENSOR_LEFT: begin
							list_pre[0] = sss_pkg::ANGLE_MIN;
							cnt_pre     = sss_pkg::count_t'(1);
						end
						sss_pkg::SENSOR_CENTER: begin
							list_pre[0] = sss_pkg::ANGLE_MID;
							cnt_pre     = sss_pkg::count_t'(1);
						end
						sss_pkg::SENSOR_RIGHT: begin
							list_pre[0] = sss_pkg::ANGLE_MAX;
							cnt_pre     = sss_pkg::count_t'(1);
						end
						sss_pkg::SENSOR_LEFT_CENTER: begin
							list_pre[0] = sss_pkg::ANGLE_MIN;
							list_pre[1] = sss_pkg::ANGLE_MID;
							cnt_pre     = sss_pkg::count_t'(2);
						end
						sss_pkg::SENSOR_CENTER_RIGHT: begin
							list_pre[0] = sss_pkg::ANGLE_MID;
							list_pre[1] = sss_pkg::ANGLE_MAX;
							cnt_pre     = sss_pkg::count_t'(2);
						end
						sss_pkg::SENSOR_SWEEP_A, sss_pkg::SENSOR_SWEEP_B: begin
							list_pre[0] = sss_pkg::ANGLE_MIN;
							list_pre[1] = sss_pkg::ANGLE_MID;
							list_pre[2] = sss_pkg::ANGLE_MID;
							list_pre[3] = sss_pkg::ANGLE_MAX;
							cnt_pre     = sss_pkg::count_t'(4);
						end
						default: begin
						end
					endcase
				end else begin
					list_pre[0] = sss_pkg::idle_target(idx_s1);
					cnt_pre     = sss_pkg::count_t'(1);
				end
				if (cnt_pre != '0) begin
					ticks_n = 3'd0;
				end
			end
		end else if (count_q != '0) begin
			if (ticks_q == 3'd0) begin
				duty_n  = sss_pkg::duty_of(angle_q);
				light_n = sss_pkg::zone_of(angle_q);
			end
			if (tick_inc >= sss_pkg::SPAN_BASE - speed_q) begin
				ticks_n = 3'd0;
				if (angle_q < tgt_q[0]) begin
					angle_n = angle_q + 8'sd1;
				end else if (angle_q > tgt_q[0]) begin
					angle_n = angle_q - 8'sd1;
				end
			end else begin
				ticks_n = tick_inc;
			end
		end

		// drop leading targets already reached
		drop_k = '0;
		run    = 1'b1;
		for (int j = 0; j < sss_pkg::TARGET_DEPTH; j++) begin
			if (run && (sss_pkg::count_t'(j) < cnt_pre) && (list_pre[j] == angle_n)) begin
				drop_k = drop_k + sss_pkg::count_t'(1);
			end else begin
				run = 1'b0;
			end
		end
		count_n = cnt_pre - drop_k;

		tgt_n = list_pre;
		for (int j = 0; j < sss_pkg::TARGET_DEPTH; j++) begin
			for (int m = 0; m < sss_pkg::TARGET_DEPTH; m++) begin
				if (m >= j && sss_pkg::count_t'(m - j) == drop_k) begin
					tgt_n[j] = list_pre[m];
				end
			end
		end

		res_n.duty_value  = duty_n;
		res_n.zone_lights = light_n;
		res_n.angle_now   = angle_n;
		res_n.busy_res    = (count_n != '0);
		res_n.speed_now   = speed_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q   <= sss_pkg::ANGLE_MIN;
			count_q   <= '0;
			speed_q   <= sss_pkg::SPEED_RESET;
			ticks_q   <= 3'd0;
			duty_q    <= 8'd0;
			light_q   <= 3'd0;
			res_valid <= 1'b0;
		end else begin
			if (adv) begin
				angle_q   <= angle_n;
				count_q   <= count_n;
				speed_q   <= speed_n;
				ticks_q   <= ticks_n;
				duty_q    <= duty_n;
				light_q   <= light_n;
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tgt_q <= tgt_n;
			res   <= res_n;
		end
	end

endmodule

FILE: rtl/sss_check.sv
module sss_check (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input sss_pkg::cmd_t cmd,
	input logic          res_valid,
	input logic          res_ready,
	input sss_pkg::res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("res changed while stalled");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid)
		else $error("cmd_ready low without a pending result");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.angle_now >= -8'sd90) && (res.angle_now <= 8'sd90))
		else $error("angle out of range");

	a_duty_speed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.duty_value == 8'd0 ||
			(res.duty_value >= 8'd125 && res.duty_value <= 8'd249)) &&
			(res.speed_now <= 3'd5))
		else $error("duty or speed out of range");

endmodule

bind servo_sweep_sequencer sss_check u_sss_check (.*);
